### hdl/rss_pkg.sv
// Shared types, codes and key helpers for the record stack with search.
`default_nettype none

package rss_pkg;

  localparam int unsigned RSS_STACK_DEPTH = 64;
  localparam int unsigned RSS_KEY_CHARS   = 8;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned AGE_W    = 7;
  localparam int unsigned SALARY_W = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STAT_W   = 3;

  localparam int unsigned S_TDATA_W = 176;
  localparam int unsigned M_TDATA_W = 176;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_READ      = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_SEARCH    = 3'd4
  } rss_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } rss_status_e;

  typedef struct packed {
    logic [SALARY_W-1:0] salary;
    logic [AGE_W-1:0]    age;
    logic [NAME_W-1:0]   name;
    logic [KEY_W-1:0]    key;
  } rss_record_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    rss_record_t       rec;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } rss_result_t;

  function automatic logic [KEY_W-1:0] key_mask(input int unsigned kc);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < kc) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic keys_equal(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                      input int unsigned kc);
    logic eq;
    logic stop;
    eq   = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i < kc && !stop) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          eq   = 1'b0;
          stop = 1'b1;
        end else if (a[8*i +: 8] == 8'h00) begin
          stop = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

### hdl/rss_mem.sv
// Record memory: one write port, one registered read port.
`default_nettype none

module rss_mem
  import rss_pkg::*;
#(
  parameter int unsigned Depth = RSS_STACK_DEPTH,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic        clk_i,
  input  wire logic        wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire rss_record_t wr_data_i,
  input  wire logic        rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output rss_record_t      rd_data_o
);

  rss_record_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/rss_ctrl.sv
// Command sequencer: entry count, memory accesses and the top-down key search.
`default_nettype none

module rss_ctrl
  import rss_pkg::*;
#(
  parameter int unsigned Depth    = RSS_STACK_DEPTH,
  parameter int unsigned KeyChars = RSS_KEY_CHARS,
  localparam int unsigned AW      = $clog2(Depth),
  localparam int unsigned CW      = $clog2(Depth + 1),
  localparam int unsigned XW      = (CW > POS_W) ? CW : POS_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire logic [CMD_W-1:0] req_cmd_i,
  input  wire logic [POS_W-1:0] req_pos_i,
  input  wire rss_record_t   req_rec_i,
  output logic               mem_wr_en_o,
  output logic [AW-1:0]      mem_wr_addr_o,
  output rss_record_t        mem_wr_data_o,
  output logic               mem_rd_en_o,
  output logic [AW-1:0]      mem_rd_addr_o,
  input  wire rss_record_t   mem_rd_data_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output rss_result_t        res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_RESP
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q;
  logic            issued_all_q;
  logic            pend_q;
  logic            pend_last_q;
  logic [KEY_W-1:0] want_q;
  rss_result_t     res_q;
  logic [STAT_W-1:0] acc_status;

  logic [XW-1:0] cnt_x, pos_x, cnt_nx;
  logic          pos_ok, full, is_empty, accept, hit;
  logic [AW-1:0] pos_slot, top_slot;
  logic [KEY_W-1:0] kmask;

  assign kmask    = key_mask(KeyChars);
  assign cnt_x    = XW'(count_q);
  assign pos_x    = XW'(req_pos_i);
  assign pos_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign full     = cnt_x >= XW'(Depth);
  assign is_empty = count_q == '0;
  assign pos_slot = AW'(cnt_x - pos_x);
  assign top_slot = AW'(cnt_x - XW'(1));
  assign accept   = req_valid_i && (state_q == ST_IDLE);
  assign hit      = keys_equal(want_q, mem_rd_data_i.key, KeyChars);

  assign req_ready_o = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_RESP;
  assign res_o       = res_q;

  assign mem_wr_data_o.key    = req_rec_i.key & kmask;
  assign mem_wr_data_o.name   = req_rec_i.name;
  assign mem_wr_data_o.age    = req_rec_i.age;
  assign mem_wr_data_o.salary = req_rec_i.salary;

  always_comb begin
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = AW'(count_q);
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = top_slot;
    count_d       = count_q;
    acc_status    = STAT_OK;
    state_d       = ST_RESP;
    if (state_q == ST_SEARCH) begin
      mem_rd_addr_o = ptr_q;
      mem_rd_en_o   = !issued_all_q && !(pend_q && (hit || pend_last_q));
    end else if (accept) begin
      case (req_cmd_i)
        CMD_PUSH: begin
          if (full) begin
            acc_status = STAT_FULL;
          end else begin
            mem_wr_en_o = 1'b1;
            count_d     = count_q + CW'(1);
          end
        end
        CMD_POP: begin
          if (is_empty) begin
            acc_status = STAT_EMPTY;
          end else begin
            mem_rd_en_o = 1'b1;
            count_d     = count_q - CW'(1);
            state_d     = ST_READ;
          end
        end
        CMD_READ: begin
          mem_rd_addr_o = pos_slot;
          if (!pos_ok) begin
            acc_status = STAT_BADPOS;
          end else begin
            mem_rd_en_o = 1'b1;
            state_d     = ST_READ;
          end
        end
        CMD_OVERWRITE: begin
          mem_wr_addr_o = pos_slot;
          if (!pos_ok) begin
            acc_status = STAT_BADPOS;
          end else begin
            mem_wr_en_o = 1'b1;
          end
        end
        CMD_SEARCH: begin
          if (is_empty) begin
            acc_status = STAT_EMPTY;
          end else begin
            acc_status  = STAT_NOTFOUND;
            mem_rd_en_o = 1'b1;
            state_d     = ST_SEARCH;
          end
        end
        default: begin
          acc_status = STAT_OK;
        end
      endcase
    end
  end

  assign cnt_nx = XW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      issued_all_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      want_q       <= '0;
      res_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q      <= state_d;
            count_q      <= count_d;
            res_q.status <= acc_status;
            res_q.rec    <= '0;
            res_q.count  <= cnt_nx[CNT_W-1:0];
            res_q.empty  <= count_d == '0;
            want_q       <= req_rec_i.key & kmask;
            ptr_q        <= top_slot - AW'(1);
            issued_all_q <= top_slot == '0;
            pend_q       <= 1'b1;
            pend_last_q  <= top_slot == '0;
          end
        end
        ST_READ: begin
          res_q.rec <= mem_rd_data_i;
          state_q   <= ST_RESP;
        end
        ST_SEARCH: begin
          if (pend_q && hit) begin
            res_q.rec    <= mem_rd_data_i;
            res_q.status <= STAT_OK;
            state_q      <= ST_RESP;
          end else if (pend_q && pend_last_q) begin
            state_q <= ST_RESP;
          end else begin
            pend_q      <= mem_rd_en_o;
            pend_last_q <= ptr_q == '0;
            if (mem_rd_en_o) begin
              ptr_q        <= ptr_q - AW'(1);
              issued_all_q <= ptr_q == '0;
            end
          end
        end
        ST_RESP: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/record_stack_with_search.sv
// Top level of the record stack with search: stream ports and result register.
`default_nettype none

// Last-in first-out store of up to STACK_DEPTH records (key, name, age,
// salary in hundredths) held in one single-port-read record memory. One
// request at a time: push, overwrite, unknown and refused commands go from
// acceptance straight to the result state, a successful pop and read pass
// through a memory read state first, and a key search examines entries from
// the top, one read per cycle of the record memory, up to the entry count
// and stopping at the first match. Memory contents are not cleared at
// reset; only entries below the entry count are ever read. A new request is
// taken while the previous result still waits in the output register.
module record_stack_with_search
  import rss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = RSS_STACK_DEPTH,
  parameter int unsigned KEY_CHARS   = RSS_KEY_CHARS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // position, key, name_text, age, salary (low bit up), zero filled
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]     s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // out_key, out_name, out_age, out_salary, count, empty_res (low bit up), zero filled
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // status
  output logic [STAT_W-1:0]         m_axis_tuser
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  rss_record_t   in_rec, wr_data, rd_data;
  rss_result_t   res, out_q;
  logic          res_valid, res_ready;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          out_valid_q;

  assign in_rec.key    = s_axis_tdata[70:7];
  assign in_rec.name   = s_axis_tdata[134:71];
  assign in_rec.age    = s_axis_tdata[141:135];
  assign in_rec.salary = s_axis_tdata[173:142];

  rss_ctrl #(
    .Depth    (STACK_DEPTH),
    .KeyChars (KEY_CHARS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_cmd_i     (s_axis_tuser),
    .req_pos_i     (s_axis_tdata[6:0]),
    .req_rec_i     (in_rec),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  rss_mem #(
    .Depth (STACK_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.empty, out_q.count, out_q.rec.salary,
                          out_q.rec.age, out_q.rec.name, out_q.rec.key};

endmodule

`default_nettype wire
